// File: sv/orlou_pkg.sv
package orlou_pkg;

	localparam int GRID_SIZE_DEF = 512;
	localparam int COORD_W = 9;
	localparam int VAL_W = 16;
	localparam int POS_W = 32;

	typedef enum logic [1:0] {
		CMD_RAY = 2'd0,
		CMD_READ = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_MISS = 2'd0,
		REG_HIT = 2'd1,
		REG_FLOOR = 2'd2,
		REG_CEIL = 2'd3
	} reg_idx_t;

	// One cell update request from the ray walker to the update unit.
	typedef struct packed {
		logic valid;
		logic hit;
		logic in_grid;
		logic [2*COORD_W-1:0] addr;
	} bump_t;

	// Add an increment and clamp: raise to floor first, then lower to ceiling.
	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0] v,
		input logic signed [VAL_W-1:0] inc,
		input logic signed [VAL_W-1:0] lo,
		input logic signed [VAL_W-1:0] hi
	);
		logic signed [VAL_W:0] s;
		s = $signed({v[VAL_W-1], v}) + $signed({inc[VAL_W-1], inc});
		if (s < $signed({lo[VAL_W-1], lo})) s = $signed({lo[VAL_W-1], lo});
		if (s > $signed({hi[VAL_W-1], hi})) s = $signed({hi[VAL_W-1], hi});
		return s[VAL_W-1:0];
	endfunction

endpackage

// File: sv/orlou_ram.sv
module orlou_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/orlou_div.sv
// Restoring divider: quotient = (num << 16) / den, one bit a cycle.
module orlou_div #(
	parameter int NUM_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [NUM_W-1:0] den,
	output logic             busy,
	output logic [31:0]      quot
);
	localparam int QW = NUM_W + 16;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0]   dvd_q;
	logic [NUM_W:0]  rem_q;
	logic [NUM_W-1:0] den_q;
	logic [CW-1:0]   cnt_q;
	logic [NUM_W:0]  trial;

	assign trial = {rem_q[NUM_W-1:0], dvd_q[QW-1]} - {1'b0, den_q};
	assign busy = (cnt_q != '0);
	assign quot = 32'(dvd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(QW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, 16'd0};
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			if (!trial[NUM_W]) begin
				rem_q <= trial;
				dvd_q <= {dvd_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NUM_W-1:0], dvd_q[QW-1]};
				dvd_q <= {dvd_q[QW-2:0], 1'b0};
			end
		end
	end
endmodule

// File: sv/orlou_walk.sv
// Ray walker: after any slope divide, emits one cell bump per cycle when bump_ready.
module orlou_walk #(
	parameter int GRID_SIZE = orlou_pkg::GRID_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [orlou_pkg::COORD_W-1:0]   sx,
	input  logic [orlou_pkg::COORD_W-1:0]   sy,
	input  logic [orlou_pkg::COORD_W-1:0]   ex,
	input  logic [orlou_pkg::COORD_W-1:0]   ey,
	input  logic                            bump_ready,
	output orlou_pkg::bump_t                bump,
	output logic                            done
);
	localparam int CW = orlou_pkg::COORD_W;
	localparam int PW = orlou_pkg::POS_W;

	typedef enum logic [6:0] {
		W_IDLE  = 7'b0000001,
		W_DIV   = 7'b0000010,
		W_STR   = 7'b0000100,
		W_FIRST = 7'b0001000,
		W_MID   = 7'b0010000,
		W_MID2  = 7'b0100000,
		W_LAST  = 7'b1000000
	} wst_t;

	wst_t st_q;
	logic swap_q, aneg_q, bneg_q;
	logic [CW-1:0] ma_q, cnt_q;
	logic signed [PW-1:0] a_q, b_q;
	logic [PW-1:0] slope_q;
	logic signed [CW+1:0] x_q, y_q, ex_q, ey_q;
	logic signed [1:0] xs_q, ys_q;
	logic [CW-1:0] b2_q, ai_q;

	logic signed [CW:0] dx, dy;
	logic [CW-1:0] mx, my, mb;
	logic div_start, div_busy;
	logic [PW-1:0] div_q;
	logic signed [PW-1:0] half, a_n, b_n;
	logic [CW-1:0] a_cell, b_cell, b1;
	logic a_ok, b_ok, b1_ok;

	assign dx = $signed({1'b0, ex}) - $signed({1'b0, sx});
	assign dy = $signed({1'b0, ey}) - $signed({1'b0, sy});
	assign mx = dx[CW] ? CW'(-dx) : CW'(dx);
	assign my = dy[CW] ? CW'(-dy) : CW'(dy);
	assign mb = (my < mx) ? my : mx;
	assign div_start = start && !(dx == 0 || dy == 0 || mx == my);

	orlou_div #(.NUM_W(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(mb), .den((my < mx) ? mx : my), .busy(div_busy), .quot(div_q)
	);

	function automatic logic cell_ok(input logic signed [PW-1:0] p);
		return !p[PW-1] && ((p >>> 16) < GRID_SIZE);
	endfunction

	assign half = $signed({1'b0, slope_q[PW-1:1]});
	always_comb begin
		a_n = a_q;
		b_n = b_q;
		case (st_q)
			W_FIRST, W_LAST: begin
				a_n = aneg_q ? a_q - 32'sh8000 : a_q + 32'sh8000;
				b_n = bneg_q ? b_q - half : b_q + half;
			end
			W_MID: begin
				a_n = aneg_q ? a_q - 32'sh10000 : a_q + 32'sh10000;
				b_n = bneg_q ? b_q - $signed(slope_q) : b_q + $signed(slope_q);
			end
			default: ;
		endcase
	end
	assign a_cell = CW'(a_n >>> 16);
	assign b_cell = CW'(b_n >>> 16);
	assign b1 = CW'(b_q >>> 16);
	assign a_ok = cell_ok(a_n);
	assign b_ok = cell_ok(b_n);
	assign b1_ok = cell_ok(b_q);

	always_comb begin
		bump = '0;
		case (st_q)
			W_STR: begin
				bump.valid = 1'b1;
				bump.hit = (x_q == ex_q) && (y_q == ey_q);
				bump.in_grid = 1'b1;
				bump.addr = {CW'(y_q), CW'(x_q)};
			end
			W_FIRST, W_LAST: begin
				bump.valid = 1'b1;
				bump.hit = (st_q == W_LAST);
				bump.in_grid = a_ok && b_ok;
				bump.addr = swap_q ? {a_cell, b_cell} : {b_cell, a_cell};
			end
			W_MID: begin
				bump.valid = 1'b1;
				bump.in_grid = a_ok && b1_ok;
				bump.addr = swap_q ? {a_cell, b1} : {b1, a_cell};
			end
			W_MID2: begin
				bump.valid = 1'b1;
				bump.in_grid = cell_ok(b_q) && !a_q[PW-1];
				bump.addr = swap_q ? {ai_q, b2_q} : {b2_q, ai_q};
			end
			default: ;
		endcase
	end

	assign done = (st_q == W_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= W_IDLE;
		end else begin
			case (st_q)
				W_IDLE: if (start) st_q <= div_start ? W_DIV : W_STR;
				W_DIV: if (!div_busy) st_q <= W_FIRST;
				W_STR: if (bump_ready && bump.hit) st_q <= W_IDLE;
				W_FIRST: if (bump_ready) st_q <= (ma_q > 1) ? W_MID : W_LAST;
				W_MID: if (bump_ready) begin
					if (b1 != b_cell) st_q <= W_MID2;
					else if (cnt_q + 1'b1 >= ma_q) st_q <= W_LAST;
				end
				W_MID2: if (bump_ready) st_q <= (cnt_q >= ma_q) ? W_LAST : W_MID;
				W_LAST: if (bump_ready) st_q <= W_IDLE;
				default: st_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == W_IDLE && start) begin
			swap_q <= !(my < mx);
			aneg_q <= (my < mx) ? dx[CW] : dy[CW];
			bneg_q <= (my < mx) ? dy[CW] : dx[CW];
			ma_q <= (my < mx) ? mx : my;
			a_q <= $signed({{(PW-CW-16){1'b0}}, (my < mx) ? sx : sy, 16'h8000});
			b_q <= $signed({{(PW-CW-16){1'b0}}, (my < mx) ? sy : sx, 16'h8000});
			x_q <= $signed({2'b0, sx});
			y_q <= $signed({2'b0, sy});
			ex_q <= $signed({2'b0, ex});
			ey_q <= $signed({2'b0, ey});
			xs_q <= (dx == 0) ? 2'sd0 : (dx[CW] ? -2'sd1 : 2'sd1);
			ys_q <= (dy == 0) ? 2'sd0 : (dy[CW] ? -2'sd1 : 2'sd1);
			cnt_q <= CW'(1);
		end
		if (st_q == W_DIV) begin
			slope_q <= div_q;
		end
		if (bump_ready) begin
			case (st_q)
				W_STR: begin
					x_q <= x_q + xs_q;
					y_q <= y_q + ys_q;
				end
				W_FIRST, W_LAST: begin
					a_q <= a_n;
					b_q <= b_n;
				end
				W_MID: begin
					a_q <= a_n;
					b_q <= b_n;
					ai_q <= a_cell;
					b2_q <= b_cell;
					cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

// File: sv/occupancy_ray_log_odds_update.sv
// Log-odds occupancy grid, GRID_SIZE x GRID_SIZE cells of Q8.8 in one RAM.
// Each command returns one item with the end cell's value. A ray updates each
// stepped cell inside the grid (issue the RAM read, wait for the data, write
// back, no overlap) and skips stepped cells outside the grid; rays that are
// neither straight nor diagonal first run the serial slope divide. After the
// walk the end cell is read back into the output register. A clear, and the
// pass after reset, sweep the whole RAM at one cell a cycle; no item is taken
// then. A finished command holds in T_OUT2 while the previous result still
// waits on the output.
module occupancy_ray_log_odds_update #(
	parameter int GRID_SIZE = orlou_pkg::GRID_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[1:0], start_col[10:2], start_row[19:11], end_col[28:20],
	// end_row[37:29], zero fill
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cell_value[15:0], done_res[16], zero fill
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int CW = orlou_pkg::COORD_W;
	localparam int VW = orlou_pkg::VAL_W;
	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [6:0] {
		T_CLR  = 7'b0000001,
		T_IDLE = 7'b0000010,
		T_WALK = 7'b0000100,
		T_RD   = 7'b0001000,
		T_WR   = 7'b0010000,
		T_OUT  = 7'b0100000,
		T_OUT2 = 7'b1000000
	} tst_t;

	tst_t st_q;
	logic [AW:0] clr_q;
	logic signed [VW-1:0] miss_q, hit_q, floor_q, ceil_q;
	logic [CW-1:0] ex_q, ey_q;
	logic busy_q, hit_s1;
	logic [AW-1:0] addr_s1;
	logic end_ok_q, out_full_q;
	logic [VW-1:0] res_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [VW-1:0] wdata, rdata;
	logic walk_start, walk_done, bump_ready;
	orlou_pkg::bump_t bump;
	logic [1:0] cmd;
	logic s_ok, in_g, out_load;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [CW-1:0] r);
		return AW'(r) * AW'(GRID_SIZE) + AW'(c);
	endfunction

	assign cmd = s_tdata[1:0];
	assign s_tready = (st_q == T_IDLE);
	assign s_ok = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_full_q;
	assign m_tdata = {7'd0, 1'b1, res_q};
	// Load the output register once it is empty or being drained.
	assign out_load = (st_q == T_OUT2) && (!out_full_q || m_tready);
	assign in_g = (s_tdata[10:2] < GRID_SIZE) && (s_tdata[19:11] < GRID_SIZE)
		&& (s_tdata[28:20] < GRID_SIZE) && (s_tdata[37:29] < GRID_SIZE);
	assign walk_start = s_ok && (cmd == orlou_pkg::CMD_RAY) && in_g;
	// Walker advances only when the update unit is free.
	assign bump_ready = (st_q == T_WALK) && !bump.valid ? 1'b0 : (st_q == T_WALK);

	orlou_walk #(.GRID_SIZE(GRID_SIZE)) u_walk (
		.clk(clk), .arst_n(arst_n), .start(walk_start),
		.sx(s_tdata[10:2]), .sy(s_tdata[19:11]), .ex(s_tdata[28:20]), .ey(s_tdata[37:29]),
		.bump_ready(bump_ready), .bump(bump), .done(walk_done)
	);

	// Hold the bumped cell's address until its value is written back.
	assign raddr = (st_q == T_WALK) ? cell_addr(bump.addr[CW-1:0], bump.addr[2*CW-1:CW])
		: (st_q == T_RD || st_q == T_WR) ? addr_s1
		: cell_addr(ex_q, ey_q);
	assign we = (st_q == T_CLR) || (st_q == T_WR);
	assign waddr = (st_q == T_CLR) ? clr_q[AW-1:0] : addr_s1;
	assign wdata = (st_q == T_CLR) ? '0
		: orlou_pkg::sat_add($signed(rdata), hit_s1 ? hit_q : miss_q, floor_q, ceil_q);

	orlou_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_CLR;
			clr_q <= '0;
			miss_q <= -16'sd102;
			hit_q <= 16'sd230;
			floor_q <= -16'sd1280;
			ceil_q <= 16'sd1280;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					orlou_pkg::REG_MISS: miss_q <= cfg_data;
					orlou_pkg::REG_HIT: hit_q <= cfg_data;
					orlou_pkg::REG_FLOOR: floor_q <= cfg_data;
					orlou_pkg::REG_CEIL: ceil_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				T_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DEPTH - 1)) st_q <= busy_q ? T_OUT : T_IDLE;
				end
				T_IDLE: if (s_ok) begin
					if (cmd == orlou_pkg::CMD_CLEAR) begin
						clr_q <= '0;
						st_q <= T_CLR;
					end else begin
						st_q <= walk_start ? T_WALK : T_OUT;
					end
				end
				T_WALK: begin
					if (bump.valid) st_q <= bump.in_grid ? T_RD : T_WALK;
					else if (walk_done) st_q <= T_OUT;
				end
				T_RD: st_q <= T_WR;
				T_WR: st_q <= T_WALK;
				T_OUT: st_q <= T_OUT2;
				T_OUT2: if (out_load) st_q <= T_IDLE;
				default: st_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (out_load) begin
			out_full_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			out_full_q <= 1'b0;
		end
	end

	// Mark an item in flight, so the sweep after reset returns no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (s_ok) begin
			busy_q <= 1'b1;
		end else if (out_load) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == T_IDLE && s_ok) begin
			ex_q <= s_tdata[28:20];
			ey_q <= s_tdata[37:29];
			end_ok_q <= (s_tdata[28:20] < GRID_SIZE) && (s_tdata[37:29] < GRID_SIZE);
		end
		if (st_q == T_WALK) begin
			addr_s1 <= raddr;
			hit_s1 <= bump.hit;
		end
		if (out_load) begin
			res_q <= end_ok_q ? rdata : '0;
		end
	end
endmodule

// File: sv/orlou_check.sv
module orlou_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[16]) else $error("done flag low");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second item taken at once");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:17] == 7'd0) else $error("fill bits set");
endmodule

bind occupancy_ray_log_odds_update orlou_check u_check (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// File: sim/ray_update_checker.sv
`timescale 1ns / 100ps

module ray_update_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);
	localparam int SIDE = orlou_pkg::GRID_SIZE_DEF;

	// Two-state cells start at zero, as the grid does after reset.
	shortint grid_model [SIDE*SIDE];
	int miss_inc = -102;
	int hit_inc = 230;
	int floor_val = -1280;
	int ceil_val = 1280;
	logic signed [15:0] cell_queue [$];

	task automatic clear_grid();
		for (int k = 0; k < SIDE*SIDE; k++) grid_model[k] = '0;
	endtask

	task automatic add_to_cell(input int col, input int row, input int inc);
		int v;
		if (col < 0 || row < 0 || col >= SIDE || row >= SIDE) return;
		v = int'(grid_model[row*SIDE+col]) + inc;
		if (v < floor_val) v = floor_val;
		if (v > ceil_val) v = ceil_val;
		grid_model[row*SIDE+col] = v[15:0];
	endtask

	function automatic int cell_index(input int pos);
		return pos < 0 ? -1 : (pos >>> 16);
	endfunction

	task automatic add_major_minor(input int a, input int b, input bit swapped, input int inc);
		if (swapped) add_to_cell(b, a, inc);
		else add_to_cell(a, b, inc);
	endtask

	// Fixed-point walk along the major axis; first and last steps are half steps.
	task automatic walk_major(input int sa, input int sb, input int ea, input int eb,
		input bit swapped);
		int da, db, ma, mb, asg, bsg, slope, a, b, ai, b1, b2;
		da = ea - sa;
		db = eb - sb;
		ma = da < 0 ? -da : da;
		mb = db < 0 ? -db : db;
		asg = da < 0 ? -1 : 1;
		bsg = db < 0 ? -1 : 1;
		slope = (mb << 16) / ma;
		a = sa * 65536 + 32768;
		b = sb * 65536 + 32768;
		a += asg * 32768;
		b += bsg * (slope >>> 1);
		add_major_minor(cell_index(a), cell_index(b), swapped, miss_inc);
		for (int i = 1; i < ma; i++) begin
			a += asg * 65536;
			ai = cell_index(a);
			b1 = cell_index(b);
			b += bsg * slope;
			b2 = cell_index(b);
			add_major_minor(ai, b1, swapped, miss_inc);
			if (b1 != b2) add_major_minor(ai, b2, swapped, miss_inc);
		end
		a += asg * 32768;
		b += bsg * (slope >>> 1);
		add_major_minor(cell_index(a), cell_index(b), swapped, hit_inc);
	endtask

	task automatic trace_ray(input int sx, input int sy, input int ex, input int ey);
		int dx, dy, mx, my, xs, ys, x, y;
		dx = ex - sx;
		dy = ey - sy;
		mx = dx < 0 ? -dx : dx;
		my = dy < 0 ? -dy : dy;
		if (dx == 0 || dy == 0 || mx == my) begin
			xs = dx < 0 ? -1 : (dx > 0 ? 1 : 0);
			ys = dy < 0 ? -1 : (dy > 0 ? 1 : 0);
			x = sx;
			y = sy;
			while (x != ex || y != ey) begin
				add_to_cell(x, y, miss_inc);
				x += xs;
				y += ys;
			end
			add_to_cell(ex, ey, hit_inc);
		end else if (my < mx) begin
			walk_major(sx, sy, ex, ey, 1'b0);
		end else begin
			walk_major(sy, sx, ey, ex, 1'b1);
		end
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	assign pending = cell_queue.size();

	always @(posedge clk) begin
		orlou_pkg::cmd_t cmd;
		int sc, sr, ec, er;
		logic signed [15:0] want;
		if (arst_n && cfg_valid && cfg_ready) begin
			case (orlou_pkg::reg_idx_t'(cfg_index))
				orlou_pkg::REG_MISS: miss_inc = $signed(cfg_data);
				orlou_pkg::REG_HIT: hit_inc = $signed(cfg_data);
				orlou_pkg::REG_FLOOR: floor_val = $signed(cfg_data);
				orlou_pkg::REG_CEIL: ceil_val = $signed(cfg_data);
				default: ;
			endcase
		end
		if (arst_n && s_tvalid && s_tready) begin
			cmd = orlou_pkg::cmd_t'(s_tdata[1:0]);
			sc = s_tdata[10:2];
			sr = s_tdata[19:11];
			ec = s_tdata[28:20];
			er = s_tdata[37:29];
			if (cmd == orlou_pkg::CMD_RAY) trace_ray(sc, sr, ec, er);
			else if (cmd == orlou_pkg::CMD_CLEAR) clear_grid();
			cell_queue.push_back(grid_model[er*SIDE+ec]);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (cell_queue.size() == 0) begin
				report("unexpected result, cell_value", $signed(m_tdata[15:0]), 0);
			end else begin
				want = cell_queue.pop_front();
				if (m_tdata[15:0] !== want)
					report("cell_value", $signed(m_tdata[15:0]), want);
				if (m_tdata[16] !== 1'b1) report("done_res", m_tdata[16], 1);
			end
		end
	end
endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	localparam int CYCLE_LIMIT = 6_000_000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          errors;
	int          pending;
	int          sent_items;
	int          cycles;
	bit          calm;
	bit          hold_rx;
	int          center_col, center_row;
	int          last_col, last_row;

	occupancy_ray_log_odds_update i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ray_update_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_rx) m_tready <= 1'b0;
		else if (!calm && $urandom_range(99) < 9) m_tready <= 1'b0;
		else m_tready <= 1'b1;
	end

	// Hold off the receiver long enough that the block backs up into its input.
	initial begin
		wait (sent_items >= 700);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (500) @(posedge clk);
		hold_rx <= 1'b0;
	end

	task automatic send_item(input orlou_pkg::cmd_t cmd, input int sc, input int sr,
		input int ec, input int er);
		while (!calm && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, er[8:0], ec[8:0], sr[8:0], sc[8:0], cmd};
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	task automatic write_reg(input orlou_pkg::reg_idx_t idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[15:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input int miss, input int hit, input int lo, input int hi);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (10) @(posedge clk);
		write_reg(orlou_pkg::REG_MISS, miss);
		write_reg(orlou_pkg::REG_HIT, hit);
		write_reg(orlou_pkg::REG_FLOOR, lo);
		write_reg(orlou_pkg::REG_CEIL, hi);
		cfg_valid <= 1'b0;
	endtask

	function automatic int near(input int base, input int span);
		int v;
		v = base + $urandom_range(2*span) - span;
		return v < 0 ? 0 : (v > 511 ? 511 : v);
	endfunction

	// Mostly short rays around a wandering center so cells pile up and saturate.
	task automatic random_items(input int count, input bit with_clear);
		int sc, sr, ec, er, pick;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(19) == 0) begin
				center_col = $urandom_range(511);
				center_row = $urandom_range(511);
			end
			pick = $urandom_range(99);
			if (with_clear && n == count / 2) begin
				send_item(orlou_pkg::CMD_CLEAR, $urandom_range(511), $urandom_range(511),
					last_col, last_row);
			end else if (pick < 70) begin
				if ($urandom_range(49) == 0) begin
					sc = $urandom_range(511); sr = $urandom_range(511);
					ec = $urandom_range(511); er = $urandom_range(511);
				end else begin
					sc = near(center_col, 8); sr = near(center_row, 8);
					ec = near(sc, 16); er = near(sr, 16);
				end
				send_item(orlou_pkg::CMD_RAY, sc, sr, ec, er);
				last_col = ec;
				last_row = er;
			end else if (pick < 95) begin
				if (pick < 85) begin
					ec = last_col; er = last_row;
				end else begin
					ec = near(center_col, 20); er = near(center_row, 20);
				end
				send_item(orlou_pkg::CMD_READ, $urandom_range(511), $urandom_range(511),
					ec, er);
			end else begin
				send_item(orlou_pkg::CMD_NONE, $urandom_range(511), $urandom_range(511),
					near(last_col, 1), near(last_row, 1));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		sent_items = 0;
		calm = 1'b0;
		hold_rx = 1'b0;
		center_col = 256;
		center_row = 256;
		last_col = 0;
		last_row = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(orlou_pkg::CMD_READ, 0, 0, 0, 0);
		send_item(orlou_pkg::CMD_READ, 511, 511, 511, 511);
		send_item(orlou_pkg::CMD_RAY, 10, 10, 10, 10);
		send_item(orlou_pkg::CMD_RAY, 5, 20, 15, 20);
		send_item(orlou_pkg::CMD_RAY, 30, 40, 30, 25);
		send_item(orlou_pkg::CMD_RAY, 50, 50, 60, 60);
		send_item(orlou_pkg::CMD_RAY, 70, 60, 60, 70);
		send_item(orlou_pkg::CMD_RAY, 100, 100, 117, 105);
		send_item(orlou_pkg::CMD_RAY, 120, 130, 116, 110);
		send_item(orlou_pkg::CMD_RAY, 200, 200, 187, 193);
		send_item(orlou_pkg::CMD_RAY, 0, 0, 511, 300);
		send_item(orlou_pkg::CMD_RAY, 511, 511, 0, 0);
		send_item(orlou_pkg::CMD_RAY, 511, 0, 0, 511);
		send_item(orlou_pkg::CMD_RAY, 300, 0, 301, 511);
		send_item(orlou_pkg::CMD_NONE, 0, 0, 117, 105);
		send_item(orlou_pkg::CMD_READ, 511, 511, 100, 100);
		send_item(orlou_pkg::CMD_READ, 0, 0, 511, 0);
		send_item(orlou_pkg::CMD_CLEAR, 7, 7, 60, 60);
		send_item(orlou_pkg::CMD_READ, 0, 0, 511, 511);
		for (int k = 0; k < 12; k++) send_item(orlou_pkg::CMD_RAY, 40, 40, 43, 41);
		send_item(orlou_pkg::CMD_READ, 0, 0, 43, 41);

		load_settings(-32768, 32767, -32768, 32767);
		calm = 1'b1;
		random_items(150, 1'b0);
		calm = 1'b0;
		random_items(200, 1'b0);
		load_settings(300, -700, 500, -500);
		random_items(300, 1'b0);
		load_settings(200, -50, -2000, 2000);
		random_items(350, 1'b1);
		load_settings(-400, 1000, -300, 32767);
		random_items(350, 1'b0);
		load_settings($urandom_range(65535), $urandom_range(65535),
			-$urandom_range(4000), $urandom_range(4000));
		random_items(300, 1'b0);

		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

// File: filelist.f
sv/orlou_pkg.sv
sv/orlou_ram.sv
sv/orlou_div.sv
sv/orlou_walk.sv
sv/occupancy_ray_log_odds_update.sv
sv/orlou_check.sv
sim/ray_update_checker.sv
sim/testbench.sv
